### sv/dscf_pkg.sv
// shared types, constants and helper functions of the drive/steer command framer
package dscf_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 12;
  localparam int unsigned PROD_W  = 16;
  localparam int unsigned QUO_W   = 9;
  localparam int unsigned SLOPE_W = 9;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DRIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_STEER = 2'd1;
  localparam logic [BYTE_W-1:0]    STOP_VALUE_RST = 8'd127;

  // mapping constants
  localparam logic [BYTE_W-1:0] NEUTRAL_BYTE = 8'd127;
  localparam logic [6:0]        DIV_LO       = 7'd127;
  localparam logic [9:0]        RECIP_LO     = 10'd516;
  localparam int unsigned       RECIP_SHIFT  = 16;
  localparam int unsigned       DIV_HI_SHIFT = 7;
  localparam int unsigned       NUM_LANES    = 2;
  localparam int unsigned       LANE_THR     = 0;
  localparam int unsigned       LANE_STR     = 1;

  // per lane: throttle first, steering second
  localparam logic [CODE_W-1:0]  LANE_BASE     [NUM_LANES] = '{12'h3B3, 12'h381};
  localparam logic [SLOPE_W-1:0] LANE_SLOPE_LO [NUM_LANES] = '{9'd141, 9'd302};
  localparam logic [SLOPE_W-1:0] LANE_SLOPE_HI [NUM_LANES] = '{9'd70, 9'd388};
  localparam logic               LANE_ADD_LO   [NUM_LANES] = '{1'b1, 1'b0};
  localparam logic               LANE_ADD_HI   [NUM_LANES] = '{1'b0, 1'b1};

  // frame bytes
  localparam logic [BYTE_W-1:0] LEAD_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] STX_BYTE   = 8'h02;
  localparam logic [BYTE_W-1:0] ETX_BYTE   = 8'h03;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_ONE  = 8'h31;
  localparam logic [BYTE_W-1:0] ASCII_A    = 8'h41;

  // byte positions within the frame
  localparam logic [IDX_W-1:0] POS_LEAD  = 4'd0;
  localparam logic [IDX_W-1:0] POS_STX   = 4'd1;
  localparam logic [IDX_W-1:0] POS_THR2  = 4'd2;
  localparam logic [IDX_W-1:0] POS_THR1  = 4'd3;
  localparam logic [IDX_W-1:0] POS_THR0  = 4'd4;
  localparam logic [IDX_W-1:0] POS_STR2  = 4'd5;
  localparam logic [IDX_W-1:0] POS_STR1  = 4'd6;
  localparam logic [IDX_W-1:0] POS_STR0  = 4'd7;
  localparam logic [IDX_W-1:0] POS_MODE0 = 4'd8;
  localparam logic [IDX_W-1:0] POS_MODE1 = 4'd9;
  localparam logic [IDX_W-1:0] POS_ETX   = 4'd10;

  // request types
  typedef struct packed {
    logic [BYTE_W-1:0] drive_command;
    logic [BYTE_W-1:0] steer_command;
    logic              stop_request;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;
  } out_item_t;

  // classified command waiting for the serialiser
  typedef struct packed {
    logic [CODE_W-1:0] throttle_code;
    logic [CODE_W-1:0] steering_code;
    logic              stopped;
  } frame_job_t;

  // uppercase ascii hex digit
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] d;
    if (nib < 4'd10) begin
      d = ASCII_ZERO + {4'd0, nib};
    end else begin
      d = ASCII_A + {4'd0, nib} - 8'd10;
    end
    return d;
  endfunction

  // byte of the frame at a given position
  function automatic logic [BYTE_W-1:0] frame_byte_at(input logic [IDX_W-1:0] pos,
                                                      input frame_job_t job);
    logic [BYTE_W-1:0] b;
    case (pos)
      POS_LEAD:  b = LEAD_BYTE;
      POS_STX:   b = STX_BYTE;
      POS_THR2:  b = hex_digit(job.throttle_code[11:8]);
      POS_THR1:  b = hex_digit(job.throttle_code[7:4]);
      POS_THR0:  b = hex_digit(job.throttle_code[3:0]);
      POS_STR2:  b = hex_digit(job.steering_code[11:8]);
      POS_STR1:  b = hex_digit(job.steering_code[7:4]);
      POS_STR0:  b = hex_digit(job.steering_code[3:0]);
      POS_MODE0: b = job.stopped ? ASCII_ONE : ASCII_ZERO;
      POS_MODE1: b = ASCII_ONE;
      POS_ETX:   b = ETX_BYTE;
      default:   b = LEAD_BYTE;
    endcase
    return b;
  endfunction

endpackage

### sv/dscf_front.sv
// front end: takes commands, applies stop values and maps them to throttle and steering codes
module dscf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  dscf_pkg::in_item_t        in_data,
  input  logic [dscf_pkg::BYTE_W-1:0] stop_drive,
  input  logic [dscf_pkg::BYTE_W-1:0] stop_steer,
  output logic                      push_valid,
  input  logic                      push_ready,
  output dscf_pkg::frame_job_t      push_data
);

  localparam int unsigned NL = dscf_pkg::NUM_LANES;

  // pipeline valid bits
  logic v1_r, v2_r, v3_r;
  logic adv;

  // stage 1: product of distance from neutral and slope
  logic [dscf_pkg::PROD_W-1:0] p1_r   [NL];
  logic [dscf_pkg::PROD_W-1:0] p1_nxt [NL];
  logic                        lo1_r  [NL];
  logic                        lo1_nxt[NL];
  logic                        stop1_r;

  // stage 2: quotient estimate
  logic [dscf_pkg::PROD_W-1:0] p2_r    [NL];
  logic [dscf_pkg::QUO_W-1:0]  est2_r  [NL];
  logic [dscf_pkg::QUO_W-1:0]  est2_nxt[NL];
  logic                        lo2_r   [NL];
  logic                        stop2_r;

  // stage 3: corrected quotient applied to the base code
  logic [dscf_pkg::CODE_W-1:0] code3_r  [NL];
  logic [dscf_pkg::CODE_W-1:0] code3_nxt[NL];
  logic                        stop3_r;

  // whole pipe moves unless the last stage is blocked by a full queue
  assign adv        = !v3_r || push_ready;
  assign in_ready   = adv;
  assign push_valid = v3_r;
  assign push_data  = '{throttle_code: code3_r[dscf_pkg::LANE_THR],
                        steering_code: code3_r[dscf_pkg::LANE_STR],
                        stopped:       stop3_r};

  // stage 1 logic: byte selection, distance and slope product
  always_comb begin
    logic [dscf_pkg::BYTE_W-1:0]  v;
    logic [dscf_pkg::BYTE_W-1:0]  delta;
    logic [dscf_pkg::SLOPE_W-1:0] slope;
    for (int l = 0; l < NL; l++) begin
      if (l == dscf_pkg::LANE_THR) begin
        v = in_data.stop_request ? stop_drive : in_data.drive_command;
      end else begin
        v = in_data.stop_request ? stop_steer : in_data.steer_command;
      end
      lo1_nxt[l] = v < dscf_pkg::NEUTRAL_BYTE;
      delta      = lo1_nxt[l] ? (dscf_pkg::NEUTRAL_BYTE - v) : (v - dscf_pkg::NEUTRAL_BYTE);
      slope      = lo1_nxt[l] ? dscf_pkg::LANE_SLOPE_LO[l] : dscf_pkg::LANE_SLOPE_HI[l];
      p1_nxt[l]  = dscf_pkg::PROD_W'({8'd0, delta} * {7'd0, slope});
    end
  end

  // stage 2 logic: reciprocal estimate for /127, shift for /128
  always_comb begin
    logic [dscf_pkg::PROD_W+9:0] prod;
    for (int l = 0; l < NL; l++) begin
      prod = {10'd0, p1_r[l]} * {16'd0, dscf_pkg::RECIP_LO};
      if (lo1_r[l]) begin
        est2_nxt[l] = dscf_pkg::QUO_W'(prod >> dscf_pkg::RECIP_SHIFT);
      end else begin
        est2_nxt[l] = dscf_pkg::QUO_W'(p1_r[l] >> dscf_pkg::DIV_HI_SHIFT);
      end
    end
  end

  // stage 3 logic: one-step correction and offset from the base code
  always_comb begin
    logic [dscf_pkg::PROD_W-1:0] rem;
    logic [dscf_pkg::QUO_W-1:0]  quo;
    logic                        add;
    for (int l = 0; l < NL; l++) begin
      rem = p2_r[l] - dscf_pkg::PROD_W'({7'd0, est2_r[l]} * {9'd0, dscf_pkg::DIV_LO});
      quo = est2_r[l];
      if (lo2_r[l] && (rem >= {9'd0, dscf_pkg::DIV_LO})) begin
        quo = est2_r[l] + 9'd1;
      end
      add = lo2_r[l] ? dscf_pkg::LANE_ADD_LO[l] : dscf_pkg::LANE_ADD_HI[l];
      code3_nxt[l] = add ? (dscf_pkg::LANE_BASE[l] + {3'd0, quo})
                         : (dscf_pkg::LANE_BASE[l] - {3'd0, quo});
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NL; l++) begin
        p1_r[l]    <= p1_nxt[l];
        lo1_r[l]   <= lo1_nxt[l];
        p2_r[l]    <= p1_r[l];
        est2_r[l]  <= est2_nxt[l];
        lo2_r[l]   <= lo1_r[l];
        code3_r[l] <= code3_nxt[l];
      end
      stop1_r <= in_data.stop_request;
      stop2_r <= stop1_r;
      stop3_r <= stop2_r;
    end
  end

endmodule

### sv/dscf_queue.sv
// short queue of mapped commands between front end and serialiser
module dscf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  dscf_pkg::frame_job_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output dscf_pkg::frame_job_t pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dscf_pkg::frame_job_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic push, pop;

  assign push_ready = count_r != CNT_FULL;
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/dscf_back.sv
// back end: serialises one mapped command into the eleven frame bytes
module dscf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  dscf_pkg::frame_job_t job_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dscf_pkg::out_item_t  out_data
);

  logic                         active_r, active_nxt;
  logic [dscf_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  dscf_pkg::frame_job_t         cur_r, cur_nxt;
  logic                         out_valid_r, out_valid_nxt;
  dscf_pkg::out_item_t          out_data_r, out_data_nxt;
  logic                         slot_free;
  logic                         emit;
  logic [dscf_pkg::IDX_W-1:0]   pos;
  dscf_pkg::frame_job_t         src;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // output register can take a byte when empty or being drained
  assign slot_free = !out_valid_r || out_ready;
  assign job_ready = slot_free && !active_r;
  assign emit      = slot_free && (active_r || job_valid);
  assign pos       = active_r ? idx_r : dscf_pkg::POS_LEAD;
  assign src       = active_r ? cur_r : job_data;

  // next byte, position and frame state
  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.frame_byte = dscf_pkg::frame_byte_at(pos, src);
      out_data_nxt.last_byte  = pos == dscf_pkg::POS_ETX;
      cur_nxt                 = src;
      if (pos == dscf_pkg::POS_ETX) begin
        active_nxt = 1'b0;
        idx_nxt    = dscf_pkg::POS_LEAD;
      end else begin
        active_nxt = 1'b1;
        idx_nxt    = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= dscf_pkg::POS_LEAD;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  // last marker only ever sits on the etx byte
  a_last_is_etx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_byte |-> out_data_r.frame_byte == dscf_pkg::ETX_BYTE)
    else $error("last marker on a byte other than etx");

  // a new request is only taken between frames
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_ready |-> !active_r && idx_r == dscf_pkg::POS_LEAD)
    else $error("request taken in the middle of a frame");

  // inside a frame the position stays past the lead byte and within the frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r != dscf_pkg::POS_LEAD) && (idx_r <= dscf_pkg::POS_ETX))
    else $error("frame position out of range");

  // a frame ends only after its etx byte has been issued
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) && $past(rst_n) |-> $past(idx_r) == dscf_pkg::POS_ETX
      && out_data_r.last_byte)
    else $error("frame ended before etx");

endmodule

### sv/drive_steer_command_framer_unit.sv
// top level of the drive/steer command framer
//
// Each request of drive byte, steering byte and stop flag becomes an 11-byte frame
// (0x00, STX, three hex digits of throttle, three of steering, the mode pair, ETX),
// delivered one byte per cycle while out_ready is high on the out_ channel, with
// last_byte set on ETX. The output port sets the sustained request rate, with frames
// following each other without gaps. A three-stage front end maps the bytes
// (multiply, reciprocal divide, correction); a request passes its stage registers,
// the queue and the serialiser's output register before the first byte of its frame
// leaves; a queue of QUEUE_DEPTH mapped requests lets the front end keep taking
// requests while the serialiser is busy. Configuration writes (register 0 stop drive
// value, register 1 stop steering value, other indexes ignored) are always taken and
// should only be issued while the block is idle.
module drive_steer_command_framer_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dscf_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dscf_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dscf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dscf_pkg::BYTE_W-1:0]      cfg_data
);

  logic [dscf_pkg::BYTE_W-1:0] stop_drive_r;
  logic [dscf_pkg::BYTE_W-1:0] stop_steer_r;

  logic                 push_valid, push_ready;
  dscf_pkg::frame_job_t push_data;
  logic                 job_valid, job_ready;
  dscf_pkg::frame_job_t job_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_drive_r <= dscf_pkg::STOP_VALUE_RST;
      stop_steer_r <= dscf_pkg::STOP_VALUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dscf_pkg::REG_STOP_DRIVE: stop_drive_r <= cfg_data;
        dscf_pkg::REG_STOP_STEER: stop_steer_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // mapping front end
  dscf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .stop_drive (stop_drive_r),
    .stop_steer (stop_steer_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // queue of mapped requests
  dscf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_data   (job_data)
  );

  // frame serialiser
  dscf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/tb_drive_steer_command_framer_unit.sv
`timescale 1ns / 1ps
// self-checking testbench of the drive/steer command framer: frames predicted per request
module tb_drive_steer_command_framer_unit;

  localparam int unsigned FRAME_LEN       = 11;
  localparam int unsigned RANDOM_REQUESTS = 270;
  localparam int unsigned REQS_PER_CFG    = 80;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES     = 40;
  localparam int unsigned MAX_PRINTED     = 60;

  // register indexes with nothing behind them
  localparam logic [dscf_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [dscf_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // end points of the throttle and steering maps
  localparam int THR_NEUTRAL   = 'h3B3;
  localparam int THR_FWD_MAX   = 'h440;
  localparam int THR_REV_MIN   = 'h36D;
  localparam int STR_CENTRE    = 'h381;
  localparam int STR_LEFT_MIN  = 'h253;
  localparam int STR_RIGHT_MAX = 'h505;
  localparam int CMD_NEUTRAL   = 127;
  localparam int LO_SPAN       = 127;
  localparam int HI_SPAN       = 128;

  localparam logic [8*16-1:0] HEX_ALPHABET = "0123456789ABCDEF";

  // command bytes around the breakpoints of the maps
  localparam logic [dscf_pkg::BYTE_W-1:0] EDGE_POINTS [7] = '{8'd0, 8'd1, 8'd126, 8'd127,
                                                               8'd128, 8'd254, 8'd255};

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  dscf_pkg::in_item_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  dscf_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [dscf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dscf_pkg::BYTE_W-1:0]    cfg_data  = '0;

  // expected frame bytes, oldest first, and the shadow of the stop registers
  dscf_pkg::out_item_t         expected_bytes [$];
  logic [dscf_pkg::BYTE_W-1:0] stop_drive_shadow = 8'd127;
  logic [dscf_pkg::BYTE_W-1:0] stop_steer_shadow = 8'd127;
  int unsigned                 fail_count = 0;
  int unsigned                 bytes_seen = 0;

  // long receiver hold-off, requested by bumping the sequence number
  int unsigned hold_off_seq  = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned rx_phase_left = 0;
  int unsigned rx_tick       = 0;
  rx_mode_t    rx_mode       = RX_ALWAYS;
  int unsigned idle_cycles   = 0;

  drive_steer_command_framer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // throttle code of a drive byte
  function automatic logic [dscf_pkg::CODE_W-1:0] throttle_of(
      input logic [dscf_pkg::BYTE_W-1:0] d);
    int x;
    int v;
    x = int'(d);
    if (x < CMD_NEUTRAL) begin
      v = THR_NEUTRAL + ((CMD_NEUTRAL - x) * (THR_FWD_MAX - THR_NEUTRAL)) / LO_SPAN;
    end else if (x > CMD_NEUTRAL) begin
      v = THR_NEUTRAL - ((x - CMD_NEUTRAL) * (THR_NEUTRAL - THR_REV_MIN)) / HI_SPAN;
    end else begin
      v = THR_NEUTRAL;
    end
    return v[dscf_pkg::CODE_W-1:0];
  endfunction

  // steering code of a steering byte
  function automatic logic [dscf_pkg::CODE_W-1:0] steering_of(
      input logic [dscf_pkg::BYTE_W-1:0] s);
    int x;
    int v;
    x = int'(s);
    if (x < CMD_NEUTRAL) begin
      v = STR_CENTRE - ((CMD_NEUTRAL - x) * (STR_CENTRE - STR_LEFT_MIN)) / LO_SPAN;
    end else if (x > CMD_NEUTRAL) begin
      v = STR_CENTRE + ((x - CMD_NEUTRAL) * (STR_RIGHT_MAX - STR_CENTRE)) / HI_SPAN;
    end else begin
      v = STR_CENTRE;
    end
    return v[dscf_pkg::CODE_W-1:0];
  endfunction

  function automatic logic [dscf_pkg::BYTE_W-1:0] ascii_hex(input logic [3:0] nib);
    return HEX_ALPHABET[8*(15 - nib) +: 8];
  endfunction

  // queue up the eleven bytes a request should produce
  task automatic predict_frame(input dscf_pkg::in_item_t req);
    logic [dscf_pkg::BYTE_W-1:0] drive;
    logic [dscf_pkg::BYTE_W-1:0] steer;
    logic [dscf_pkg::CODE_W-1:0] thr;
    logic [dscf_pkg::CODE_W-1:0] str;
    logic [dscf_pkg::BYTE_W-1:0] frame [FRAME_LEN];
    int k;
    drive = req.stop_request ? stop_drive_shadow : req.drive_command;
    steer = req.stop_request ? stop_steer_shadow : req.steer_command;
    thr = throttle_of(drive);
    str = steering_of(steer);
    frame[0]  = dscf_pkg::LEAD_BYTE;
    frame[1]  = dscf_pkg::STX_BYTE;
    frame[2]  = ascii_hex(thr[11:8]);
    frame[3]  = ascii_hex(thr[7:4]);
    frame[4]  = ascii_hex(thr[3:0]);
    frame[5]  = ascii_hex(str[11:8]);
    frame[6]  = ascii_hex(str[7:4]);
    frame[7]  = ascii_hex(str[3:0]);
    frame[8]  = req.stop_request ? dscf_pkg::ASCII_ONE : dscf_pkg::ASCII_ZERO;
    frame[9]  = dscf_pkg::ASCII_ONE;
    frame[10] = dscf_pkg::ETX_BYTE;
    for (k = 0; k < FRAME_LEN; k++) begin
      expected_bytes.push_back(dscf_pkg::out_item_t'({frame[k], k == FRAME_LEN - 1}));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [dscf_pkg::BYTE_W-1:0] got,
                                 input logic [dscf_pkg::BYTE_W-1:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("mismatch: %s, byte %0d got %h want %h at %0t",
               what, bytes_seen % FRAME_LEN, got, want, $time);
    end
  endtask

  // one request, held until taken, then predicted
  task automatic send_command(input logic [dscf_pkg::BYTE_W-1:0] drive,
                              input logic [dscf_pkg::BYTE_W-1:0] steer,
                              input logic stop);
    dscf_pkg::in_item_t req;
    req.drive_command = drive;
    req.steer_command = steer;
    req.stop_request  = stop;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_frame(req);
  endtask

  // sender gap between bursts
  task automatic idle_sender(input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding frame
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic set_register(input logic [dscf_pkg::CFG_IDX_W-1:0] idx,
                              input logic [dscf_pkg::BYTE_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dscf_pkg::REG_STOP_DRIVE: stop_drive_shadow = value;
      dscf_pkg::REG_STOP_STEER: stop_steer_shadow = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [dscf_pkg::BYTE_W-1:0] random_command();
    if ($urandom_range(0, 4) == 0) begin
      return EDGE_POINTS[$urandom_range(0, 6)];
    end
    return dscf_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic reset_block();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // reset values: neutral frame and stop frame on the default stop bytes
  task automatic test_neutral_after_reset();
    send_command(8'd127, 8'd127, 1'b0);
    send_command(8'd0, 8'd255, 1'b1);
    drain_frames();
  endtask

  // drive byte across both slopes and the neutral point
  task automatic test_drive_range();
    int k;
    for (k = 0; k < 7; k++) begin
      send_command(EDGE_POINTS[k], 8'd127, 1'b0);
    end
    drain_frames();
  endtask

  // steering byte across both slopes and the centre
  task automatic test_steer_range();
    int k;
    for (k = 0; k < 7; k++) begin
      send_command(random_command(), EDGE_POINTS[k], 1'b0);
    end
    drain_frames();
  endtask

  // stop substitution with extreme register values, spare indexes ignored
  task automatic test_stop_values();
    set_register(dscf_pkg::REG_STOP_DRIVE, 8'd0);
    set_register(dscf_pkg::REG_STOP_STEER, 8'd255);
    send_command(8'hAA, 8'h55, 1'b1);
    send_command(8'h55, 8'hAA, 1'b0);
    drain_frames();
    set_register(dscf_pkg::REG_STOP_DRIVE, 8'd255);
    set_register(dscf_pkg::REG_STOP_STEER, 8'd0);
    send_command(random_command(), random_command(), 1'b1);
    drain_frames();
    set_register(REG_SPARE_2, dscf_pkg::BYTE_W'($urandom_range(0, 255)));
    set_register(REG_SPARE_3, dscf_pkg::BYTE_W'($urandom_range(0, 255)));
    send_command(random_command(), random_command(), 1'b1);
    send_command(8'd255, 8'd0, 1'b0);
    drain_frames();
  endtask

  // bursts of random requests, stop values changed between phases
  task automatic test_random_traffic();
    int unsigned n;
    int unsigned burst_left;
    burst_left = 0;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n != 0 && n % REQS_PER_CFG == 0) begin
        drain_frames();
        set_register(dscf_pkg::REG_STOP_DRIVE, random_command());
        set_register(dscf_pkg::REG_STOP_STEER, random_command());
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
      end
      send_command(random_command(), random_command(), $urandom_range(0, 4) == 0);
      burst_left--;
    end
    drain_frames();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_back_pressure();
    int k;
    hold_off_seq <= hold_off_seq + 1;
    for (k = 0; k < 24; k++) begin
      send_command(random_command(), random_command(), $urandom_range(0, 3) == 0);
    end
    drain_frames();
  endtask

  // receiver stall pattern, with the long hold-off on demand
  always @(posedge clk) begin
    if (hold_seen != hold_off_seq) begin
      hold_seen = hold_off_seq;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (rx_phase_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(20, 120);
    end
    rx_phase_left--;
    rx_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:   out_ready <= 1'b1;
        RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ready <= (rx_tick % 5 >= 2);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  // compare each delivered byte with the oldest expectation
  always @(posedge clk) begin
    dscf_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("byte with no frame pending", out_data.frame_byte, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.frame_byte !== want.frame_byte) begin
          report_mismatch("frame_byte", out_data.frame_byte, want.frame_byte);
        end
        if (out_data.last_byte !== want.last_byte) begin
          report_mismatch("last_byte", dscf_pkg::BYTE_W'(out_data.last_byte),
                          dscf_pkg::BYTE_W'(want.last_byte));
        end
      end
      bytes_seen++;
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_block();
    test_neutral_after_reset();
    test_drive_range();
    test_steer_range();
    test_stop_values();
    test_random_traffic();
    test_back_pressure();
    drain_frames();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
sv/dscf_pkg.sv
sv/dscf_front.sv
sv/dscf_queue.sv
sv/dscf_back.sv
sv/drive_steer_command_framer_unit.sv
tb/tb_drive_steer_command_framer_unit.sv
